// ===== rtl/cip_pkg.sv =====
// shared types and constants for the ipv4 cidr parse and match block
// no dependencies; used by the parser, result, top level and checker files
package cip_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // limits
  localparam logic [11:0] OCTET_MAX  = 12'd255;
  localparam logic [5:0]  PREFIX_MAX = 6'd32;
  localparam logic [5:0]  PREFIX_SAT = 6'd33;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  // reset values of the range registers
  localparam logic [31:0] RANGE_BASE_RST  = 32'h0000_0000;
  localparam logic [31:0] RANGE_BCAST_RST = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_OCTSTART = 2'd0,
    PH_OCTDIG   = 2'd1,
    PH_PREFIX   = 2'd2,
    PH_IGNORE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_OCTET   = 3'd2,
    ST_MANY    = 3'd3,
    ST_PREFIX  = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_RANGE_BASE  = 1'b0,
    CFG_RANGE_BCAST = 1'b1
  } cfg_idx_t;

  // parse outcome at the string terminator
  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  plen;
    status_t     status;
  } parse_fin_t;

  // one result item
  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] broadcast;
    logic [5:0]  prefix_len;
    status_t     status;
    logic        inside_res;
  } result_t;

endpackage

// ===== rtl/cip_if.sv =====
// valid/ready channel interfaces for the character input and the result output
// no dependencies
interface cip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface cip_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] network;
  logic [31:0] mask;
  logic [31:0] broadcast;
  logic [5:0]  prefix_len;
  logic [2:0]  status;
  logic        inside_res;

  modport source (output valid, output network, output mask, output broadcast,
                  output prefix_len, output status, output inside_res, input ready);
  modport sink   (input valid, input network, input mask, input broadcast,
                  input prefix_len, input status, input inside_res, output ready);
endinterface

// ===== rtl/cip_parser.sv =====
// character parser: octet and prefix accumulation, error tracking
// depends on cip_pkg
module cip_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          ch,
  output cip_pkg::parse_fin_t fin
);

  cip_pkg::phase_t  phase_r, phase_nxt;
  logic [8:0]       octet_acc_r, octet_acc_nxt;
  logic [1:0]       octet_index_r, octet_index_nxt;
  logic [31:0]      addr_acc_r, addr_acc_nxt;
  logic [5:0]       prefix_acc_r, prefix_acc_nxt;
  logic             slash_seen_r, slash_seen_nxt;
  cip_pkg::status_t err_r, err_nxt;

  logic        is_digit;
  logic [3:0]  dval;
  logic [11:0] oct_mac;
  logic [8:0]  pre_mac;
  logic [4:0]  shamt;
  logic [31:0] addr_stored;

  // digit decode and accumulate terms
  assign is_digit    = (ch >= cip_pkg::CH_ZERO) && (ch <= cip_pkg::CH_NINE);
  assign dval        = ch[3:0];
  assign oct_mac     = 12'(octet_acc_r) * 12'd10 + 12'(dval);
  assign pre_mac     = 9'(prefix_acc_r) * 9'd10 + 9'(dval);
  // octet i lands at bit 24 - 8*i
  assign shamt       = {~octet_index_r, 3'b000};
  assign addr_stored = addr_acc_r | ({24'b0, octet_acc_r[7:0]} << shamt);

  // outcome seen at the terminator
  always_comb begin
    fin.status = err_r;
    fin.addr   = addr_acc_r;
    fin.plen   = cip_pkg::PREFIX_MAX;
    if (err_r == cip_pkg::ST_OK) begin
      if (phase_r == cip_pkg::PH_OCTSTART) begin
        fin.status = cip_pkg::ST_BADCHAR;
      end else if (phase_r == cip_pkg::PH_OCTDIG) begin
        fin.addr = addr_stored;
      end
    end
    if ((fin.status == cip_pkg::ST_OK) && slash_seen_r) begin
      fin.plen = prefix_acc_r;
      if (prefix_acc_r > cip_pkg::PREFIX_MAX) begin
        fin.status = cip_pkg::ST_PREFIX;
      end
    end
  end

  // parse state update per character
  always_comb begin
    phase_nxt       = phase_r;
    octet_acc_nxt   = octet_acc_r;
    octet_index_nxt = octet_index_r;
    addr_acc_nxt    = addr_acc_r;
    prefix_acc_nxt  = prefix_acc_r;
    slash_seen_nxt  = slash_seen_r;
    err_nxt         = err_r;
    if (step) begin
      if (ch == cip_pkg::CH_NUL) begin
        phase_nxt       = cip_pkg::PH_OCTSTART;
        octet_acc_nxt   = '0;
        octet_index_nxt = '0;
        addr_acc_nxt    = '0;
        prefix_acc_nxt  = '0;
        slash_seen_nxt  = 1'b0;
        err_nxt         = cip_pkg::ST_OK;
      end else if (err_r == cip_pkg::ST_OK) begin
        case (phase_r)
          cip_pkg::PH_OCTSTART: begin
            if (is_digit) begin
              octet_acc_nxt = 9'(dval);
              phase_nxt     = cip_pkg::PH_OCTDIG;
            end else begin
              err_nxt = cip_pkg::ST_BADCHAR;
            end
          end
          cip_pkg::PH_OCTDIG: begin
            if (is_digit) begin
              octet_acc_nxt = oct_mac[8:0];
              if (oct_mac > cip_pkg::OCTET_MAX) begin
                err_nxt = cip_pkg::ST_OCTET;
              end
            end else if (ch == cip_pkg::CH_DOT) begin
              if (octet_index_r == 2'd3) begin
                err_nxt = cip_pkg::ST_MANY;
              end else begin
                addr_acc_nxt    = addr_stored;
                octet_index_nxt = octet_index_r + 2'd1;
                octet_acc_nxt   = '0;
                phase_nxt       = cip_pkg::PH_OCTSTART;
              end
            end else if (ch == cip_pkg::CH_SLASH) begin
              addr_acc_nxt   = addr_stored;
              slash_seen_nxt = 1'b1;
              prefix_acc_nxt = '0;
              phase_nxt      = cip_pkg::PH_PREFIX;
            end else begin
              err_nxt = cip_pkg::ST_BADCHAR;
            end
          end
          cip_pkg::PH_PREFIX: begin
            if (is_digit) begin
              // saturate at one past the limit
              if (prefix_acc_r <= cip_pkg::PREFIX_MAX) begin
                if (pre_mac > 9'(cip_pkg::PREFIX_MAX)) begin
                  prefix_acc_nxt = cip_pkg::PREFIX_SAT;
                end else begin
                  prefix_acc_nxt = pre_mac[5:0];
                end
              end
            end else begin
              phase_nxt = cip_pkg::PH_IGNORE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cip_pkg::PH_OCTSTART;
      octet_acc_r   <= '0;
      octet_index_r <= '0;
      addr_acc_r    <= '0;
      prefix_acc_r  <= '0;
      slash_seen_r  <= 1'b0;
      err_r         <= cip_pkg::ST_OK;
    end else begin
      phase_r       <= phase_nxt;
      octet_acc_r   <= octet_acc_nxt;
      octet_index_r <= octet_index_nxt;
      addr_acc_r    <= addr_acc_nxt;
      prefix_acc_r  <= prefix_acc_nxt;
      slash_seen_r  <= slash_seen_nxt;
      err_r         <= err_nxt;
    end
  end

endmodule

// ===== rtl/cip_result.sv =====
// result formation: mask, network, broadcast and range containment test
// depends on cip_pkg
module cip_result (
  input  cip_pkg::parse_fin_t fin,
  input  logic [31:0]         range_base,
  input  logic [31:0]         range_bcast,
  output cip_pkg::result_t    res
);

  logic [31:0] mask;
  logic [31:0] net;
  logic [31:0] bc;

  // prefix mask, network and broadcast
  assign mask = ~(cip_pkg::ALL_ONES >> fin.plen);
  assign net  = fin.addr & mask;
  assign bc   = net | ~mask;

  // error results carry zero fields
  always_comb begin
    res.status = fin.status;
    if (fin.status == cip_pkg::ST_OK) begin
      res.network    = net;
      res.mask       = mask;
      res.broadcast  = bc;
      res.prefix_len = fin.plen;
      res.inside_res = (net >= range_base) && (bc <= range_bcast);
    end else begin
      res.network    = '0;
      res.mask       = '0;
      res.broadcast  = '0;
      res.prefix_len = '0;
      res.inside_res = 1'b0;
    end
  end

endmodule

// ===== rtl/ipv4_cidr_parse_and_match.sv =====
// top level of the ipv4 cidr parse and match block
// depends on cip_pkg, cip_if, cip_parser and cip_result
//
// usage
//   in_if carries one character of a dotted-decimal ipv4 address per transfer,
//   optionally followed by '/' and a prefix length; a NUL character ends the
//   string. only the NUL produces a result transfer on out_if: network, mask,
//   broadcast, prefix length, status and whether the block lies inside the
//   range held in the range_base / range_broadcast registers.
//   cfg_we/cfg_index/cfg_wdata write those registers; index 0 is range_base,
//   index 1 is range_broadcast. write them only while the block is idle.
//   a character is registered at the input and parsed from that register; a
//   NUL's result is loaded into the result register at the end of the cycle
//   in which the NUL is parsed, and out valid rises with that load.
//   throughput: one character per cycle, set by the single input register and
//   the following result register, while no NUL waits for the slot.
//   a stalled out_if holds its result; characters keep flowing until a
//   second NUL reaches the input register, which then waits for the slot.
//   reset (rst_n low, synchronous) empties both registers, clears the parse
//   state and sets range_base to 0 and range_broadcast to all ones.
module ipv4_cidr_parse_and_match (
  input  logic             clk,
  input  logic             rst_n,
  cip_in_if.sink           in_if,
  cip_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  logic             ch_valid_r;
  logic [7:0]       ch_r;
  logic             step;
  logic             is_nul;
  logic             load_out;
  logic             out_valid_r, out_valid_nxt;
  cip_pkg::result_t out_r;
  cip_pkg::parse_fin_t fin;
  cip_pkg::result_t res;
  logic [31:0]      range_base_r;
  logic [31:0]      range_bcast_r;

  // handshake: a NUL moves on only when the result slot is free
  assign is_nul        = (ch_r == cip_pkg::CH_NUL);
  assign step          = ch_valid_r && (!is_nul || !out_valid_r || out_if.ready);
  assign load_out      = step && is_nul;
  assign in_if.ready   = !ch_valid_r || step;
  assign out_valid_nxt = load_out || (out_valid_r && !out_if.ready);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      ch_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      ch_r <= in_if.ch;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_base_r  <= cip_pkg::RANGE_BASE_RST;
      range_bcast_r <= cip_pkg::RANGE_BCAST_RST;
    end else if (cfg_we) begin
      case (cip_pkg::cfg_idx_t'(cfg_index))
        cip_pkg::CFG_RANGE_BASE:  range_base_r  <= cfg_wdata;
        cip_pkg::CFG_RANGE_BCAST: range_bcast_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  cip_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (ch_r),
    .fin   (fin)
  );

  cip_result u_result (
    .fin         (fin),
    .range_base  (range_base_r),
    .range_bcast (range_bcast_r),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= res;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.network    = out_r.network;
  assign out_if.mask       = out_r.mask;
  assign out_if.broadcast  = out_r.broadcast;
  assign out_if.prefix_len = out_r.prefix_len;
  assign out_if.status     = out_r.status;
  assign out_if.inside_res = out_r.inside_res;

endmodule

// ===== rtl/cip_checker.sv =====
// port-level checks for ipv4_cidr_parse_and_match, attached by bind
// depends on cip_pkg and the top level's ports
module cip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] network,
  input logic [31:0] mask,
  input logic [31:0] broadcast,
  input logic [5:0]  prefix_len,
  input logic [2:0]  status,
  input logic        inside_res
);

  // result channel empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(network) && $stable(status))
    else $error("stalled result changed");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != cip_pkg::ST_OK) |->
      (network == '0) && (mask == '0) && (broadcast == '0) &&
      (prefix_len == '0) && !inside_res)
    else $error("error result with nonzero fields");

  // good results are a consistent block
  a_ok_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == cip_pkg::ST_OK) |->
      (prefix_len <= cip_pkg::PREFIX_MAX) && ((network & ~mask) == '0) &&
      (broadcast == (network | ~mask)))
    else $error("inconsistent network, mask or broadcast");

  // mask matches the prefix length
  a_mask_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == cip_pkg::ST_OK) |-> ($countones(mask) == prefix_len))
    else $error("mask does not match prefix length");

endmodule

bind ipv4_cidr_parse_and_match cip_checker u_cip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .network    (out_if.network),
  .mask       (out_if.mask),
  .broadcast  (out_if.broadcast),
  .prefix_len (out_if.prefix_len),
  .status     (out_if.status),
  .inside_res (out_if.inside_res)
);
